### hdl/bit_pkg.sv
// Package for the binary image thinning block.
// Holds payload structs and fixed constants; no dependencies.
package bit_pkg;
	localparam int unsigned RowBits = 64;
	localparam int unsigned IdxBits = 6;
	localparam int unsigned MaxEmit = 64;
	localparam int unsigned MinNbr = 2;
	localparam int unsigned MaxNbr = 6;

	typedef struct packed {
		logic [RowBits-1:0] row_bits;
		logic               last_row;
	} in_item_t;

	typedef struct packed {
		logic [IdxBits-1:0] out_row_index;
		logic [RowBits-1:0] out_row_bits;
		logic               last_out;
	} out_item_t;
endpackage

### hdl/binary_image_thinning.sv
// Top level of the Zhang-Suen thinning block: row store, sub-pass sweep, emit.
// Depends on bit_pkg.
// Load: a row item is taken whenever start is high (start with busy low). On the last row item, busy rises.
// Thinning: each sub-pass sweeps counts 0..H+1 through a row memory, two sub-passes per
// pass, and passes repeat until one clears nothing (data dependent).
// Emit: a read of row 0, then one result per cycle for min(H,64) rows, the receiver
// cannot stall; then the memory is cleared one row per cycle before busy falls.
// Reset: arst_n async low clears all control state; memory contents start undefined but
// rows beyond the loaded count read as zero, and the clear sweep restores zeros.
module binary_image_thinning #(
	parameter int unsigned IMAGE_WIDTH  = 64,
	parameter int unsigned IMAGE_HEIGHT = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  bit_pkg::in_item_t  in_item,
	output logic               busy,
	output logic               strobe,
	output bit_pkg::out_item_t out_item
);
	import bit_pkg::*;

	localparam int unsigned AW = $clog2(IMAGE_HEIGHT);
	localparam int unsigned CW = $clog2(IMAGE_HEIGHT + 3);
	localparam logic [RowBits-1:0] ColMask = {RowBits{1'b1}} >> (RowBits - IMAGE_WIDTH);

	typedef enum logic [2:0] {S_LOAD, S_SWEEP, S_EMIT, S_CLEAR} state_t;

	logic [RowBits-1:0] mem [IMAGE_HEIGHT];
	logic [RowBits-1:0] rd_q;

	state_t        state_q;
	logic [CW-1:0] rows_q;     // rows loaded
	logic [CW-1:0] cnt_q;      // sweep/emit/clear counter
	logic          sub_q;      // sub-pass select
	logic          changed_q;  // any pixel cleared in this pass
	logic [RowBits-1:0] above_q, cur_q; // window rows (original values)
	logic          rd_vld_q;

	// Read address: in sweep and emit, issue row cnt if loaded; data arrives next cycle.
	logic          rd_en;
	logic [CW-1:0] rd_idx;
	always_comb begin
		rd_en  = (state_q == S_SWEEP || state_q == S_EMIT) && (cnt_q < rows_q);
		rd_idx = cnt_q;
	end

	// Incoming row: zero if beyond loaded rows.
	logic [RowBits-1:0] below;
	assign below = rd_vld_q ? rd_q : '0;

	// Zhang-Suen test on cur_q with neighbors above_q and below.
	// The sub-pass must see the pre-sub-pass image, so above_q keeps original values
	// and the thinned row is written back separately.
	logic [RowBits-1:0] marks;
	always_comb begin
		logic [7:0] nb;
		logic [3:0] a, b;
		logic       m1, m2;
		marks = '0;
		for (int x = 0; x < IMAGE_WIDTH; x++) begin
			nb[0] = above_q[x];
			nb[1] = (x + 1 < IMAGE_WIDTH) ? above_q[(x + 1) % RowBits] : 1'b0;
			nb[2] = (x + 1 < IMAGE_WIDTH) ? cur_q[(x + 1) % RowBits] : 1'b0;
			nb[3] = (x + 1 < IMAGE_WIDTH) ? below[(x + 1) % RowBits] : 1'b0;
			nb[4] = below[x];
			nb[5] = (x > 0) ? below[(x + RowBits - 1) % RowBits] : 1'b0;
			nb[6] = (x > 0) ? cur_q[(x + RowBits - 1) % RowBits] : 1'b0;
			nb[7] = (x > 0) ? above_q[(x + RowBits - 1) % RowBits] : 1'b0;
			a = '0;
			b = '0;
			for (int k = 0; k < 8; k++) begin
				b = b + 4'(nb[k]);
				a = a + 4'(!nb[k] && nb[(k + 1) % 8]);
			end
			m1 = sub_q ? (nb[0] & nb[2] & nb[6]) : (nb[0] & nb[2] & nb[4]);
			m2 = sub_q ? (nb[0] & nb[4] & nb[6]) : (nb[2] & nb[4] & nb[6]);
			marks[x] = cur_q[x] && a == 4'd1 && b >= 4'(MinNbr) && b <= 4'(MaxNbr)
				&& !m1 && !m2;
		end
	end

	// Memory: single write port, registered read.
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [RowBits-1:0] wr_data;
	// Sweep: at cnt=c the window centre is row c-2 (read of c-1 arriving). Write it back.
	logic [CW-1:0] ctr_row;
	assign ctr_row = cnt_q - CW'(2);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		unique case (state_q)
			S_LOAD: begin
				wr_en   = start && (rows_q < CW'(IMAGE_HEIGHT));
				wr_addr = rows_q[AW-1:0];
				wr_data = in_item.row_bits & ColMask;
			end
			S_SWEEP: begin
				wr_en   = (cnt_q >= CW'(2)) && (ctr_row < rows_q);
				wr_addr = ctr_row[AW-1:0];
				wr_data = cur_q & ~marks;
			end
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = cnt_q[AW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_idx[AW-1:0]];
	end

	// Emit path: read row cnt into rd_q, then register it onto out_item.
	logic [CW-1:0] n_emit;
	assign n_emit = (rows_q < CW'(MaxEmit)) ? rows_q : CW'(MaxEmit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			rows_q    <= '0;
			cnt_q     <= '0;
			sub_q     <= 1'b0;
			changed_q <= 1'b0;
			rd_vld_q  <= 1'b0;
			above_q   <= '0;
			cur_q     <= '0;
			strobe    <= 1'b0;
			out_item  <= '0;
		end else begin
			rd_vld_q <= rd_en;
			strobe   <= 1'b0;
			unique case (state_q)
				S_LOAD: begin
					if (start) begin
						if (rows_q < CW'(IMAGE_HEIGHT))
							rows_q <= rows_q + CW'(1);
						if (in_item.last_row) begin
							state_q   <= S_SWEEP;
							cnt_q     <= '0;
							sub_q     <= 1'b0;
							changed_q <= 1'b0;
							above_q   <= '0;
							cur_q     <= '0;
						end
					end
				end
				S_SWEEP: begin
					// Shift window: original rows, so later rows see pre-sub-pass data.
					if (cnt_q >= CW'(1)) begin
						above_q <= cur_q;
						cur_q   <= below;
					end
					if (cnt_q >= CW'(2) && ctr_row < rows_q && marks != '0)
						changed_q <= 1'b1;
					if (cnt_q == rows_q + CW'(1)) begin
						cnt_q   <= '0;
						above_q <= '0;
						cur_q   <= '0;
						if (!sub_q) begin
							sub_q <= 1'b1;
						end else if (changed_q || marks != '0) begin
							sub_q     <= 1'b0;
							changed_q <= 1'b0;
						end else begin
							state_q <= (rows_q == '0) ? S_CLEAR : S_EMIT;
						end
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_EMIT: begin
					if (rd_vld_q) begin
						strobe                 <= 1'b1;
						out_item.out_row_index <= IdxBits'(cnt_q - CW'(1));
						out_item.out_row_bits  <= rd_q;
						out_item.last_out      <= (cnt_q == n_emit);
					end
					if (cnt_q == n_emit) begin
						state_q <= S_CLEAR;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_CLEAR: begin
					if (cnt_q + CW'(1) >= rows_q) begin
						state_q <= S_LOAD;
						rows_q  <= '0;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign busy = (state_q != S_LOAD);

	// Emit only outside loading.
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q == S_EMIT)) else $error("strobe outside emit");
	// Row count never exceeds the store depth.
	a_rows: assert property (@(posedge clk) disable iff (!arst_n)
		rows_q <= CW'(IMAGE_HEIGHT)) else $error("row count overflow");
	// Last output leaves emit.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && out_item.last_out |-> state_q == S_CLEAR) else $error("last misplaced");
endmodule
